// ----- rtl/chained_hash_int_table_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the hash table RTL
// Clocked on clock; CHT_ASSERT is quiet while reset is high, CHT_ASSERT_ALWAYS is not.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_INT_TABLE_DEFINES_SVH
`define CHAINED_HASH_INT_TABLE_DEFINES_SVH

// checked while out of reset
`define CHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define CHT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/cht_pkg.sv -----
// ---------------------------------------------------------------------------
// cht_pkg
// Word types, command/status groups and response codes of the hash table.
// ---------------------------------------------------------------------------
package cht_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int CFG_W           = 11;
   localparam int KEY_W           = 32;
   localparam int VAL_W           = 32;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [2:0] RSP_NONE = 3'd0;
   localparam logic [2:0] RSP_OK   = 3'd1;
   localparam logic [2:0] RSP_FULL = 3'd2;
   localparam logic [2:0] RSP_MISS = 3'd3;
   localparam logic [2:0] RSP_HIT  = 3'd4;

   typedef struct packed {
      logic                    mode;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] value_out;
      logic                    status;
   } rsp_type;

   typedef struct packed {
      logic       latch;
      logic       div_start;
      logic       ent_wr;
      logic       hd_wr;
      logic       walk_head;
      logic       walk_next;
      logic       tail_wr;
      logic       fill_inc;
      logic       clr_wr;
      logic [2:0] rsp_code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic size_zero;
      logic mod_done;
      logic head_zero;
      logic link_zero;
      logic key_hit;
      logic clr_last;
   } stat_type;

endpackage

// ----- rtl/cht_ram.sv -----
// ---------------------------------------------------------------------------
// cht_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1025,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [AW-1:0]            waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [AW-1:0]            raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/cht_mod.sv -----
// ---------------------------------------------------------------------------
// cht_mod
// Restoring remainder unit: 32-bit dividend modulo a narrow divisor,
// one bit per cycle.
// ---------------------------------------------------------------------------
module cht_mod #(
   parameter int IW = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cht_pkg::KEY_W-1:0] dividend,
   input  logic [IW-1:0]             divisor,
   output logic                      done,
   output logic [IW-1:0]             rem
);
   localparam int CW = $clog2(cht_pkg::KEY_W);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [cht_pkg::KEY_W-1:0] quo_ff, quo_in;
   logic [IW-1:0]             rem_ff, rem_in;
   logic [IW:0]               trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[cht_pkg::KEY_W-1]};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         // keep the partial remainder below the divisor
         if (trial >= {1'b0, divisor}) begin
            rem_in = IW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[IW-1:0];
         end
         quo_in = {quo_ff[cht_pkg::KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(cht_pkg::KEY_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;
endmodule

// ----- rtl/cht_dp.sv -----
// ---------------------------------------------------------------------------
// cht_dp
// Datapath: size and fill registers, bucket/link/entry RAMs, remainder
// unit, walk pointer and response register.
// ---------------------------------------------------------------------------
module cht_dp #(
   parameter int MAX_ENTRIES = cht_pkg::MAX_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [cht_pkg::CFG_W-1:0] csr_wdata,
   input  cht_pkg::req_type          req_data,
   input  cht_pkg::cmd_type          cmd,
   output cht_pkg::stat_type         stat,
   output logic                      rsp_valid,
   output cht_pkg::rsp_type          rsp_data
);
   localparam int SLOTS = MAX_ENTRIES + 1;
   localparam int IW    = $clog2(SLOTS);
   localparam int FW    = $clog2(MAX_ENTRIES + 2);
   localparam int EW    = cht_pkg::KEY_W + cht_pkg::VAL_W;

   logic [cht_pkg::CFG_W-1:0] size_ff, size_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [IW-1:0]             clr_ff, clr_in;
   logic [IW-1:0]             cur_ff, cur_in;
   logic [cht_pkg::KEY_W-1:0] key_ff;
   logic [cht_pkg::VAL_W-1:0] val_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   cht_pkg::rsp_type          rsp_ff, rsp_in;

   logic [IW-1:0] eff_size, slot, bucket, rem;
   logic [IW-1:0] head_rd, link_rd, walk_addr;
   logic [IW-1:0] hd_waddr, hd_wdata, lk_waddr, lk_wdata;
   logic [EW-1:0] ent_rd;
   logic          mod_done;

   always_comb begin
      if (32'(size_ff) > MAX_ENTRIES) begin
         eff_size = IW'(MAX_ENTRIES);
      end else begin
         eff_size = IW'(size_ff);
      end
   end

   assign slot      = fill_ff[IW-1:0];
   assign bucket    = rem + 1'b1;
   assign walk_addr = cmd.walk_head ? head_rd : link_rd;
   assign hd_waddr  = cmd.clr_wr ? clr_ff : bucket;
   assign hd_wdata  = cmd.clr_wr ? '0 : slot;
   assign lk_waddr  = cmd.ent_wr ? slot : cur_ff;
   assign lk_wdata  = cmd.ent_wr ? '0 : slot;

   cht_mod #(.IW(IW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_data.key),
      .divisor  (eff_size),
      .done     (mod_done),
      .rem      (rem)
   );

   cht_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_heads (
      .clock (clock),
      .we    (cmd.clr_wr | cmd.hd_wr),
      .waddr (hd_waddr),
      .wdata (hd_wdata),
      .raddr (bucket),
      .rdata (head_rd)
   );

   cht_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_links (
      .clock (clock),
      .we    (cmd.ent_wr | cmd.tail_wr),
      .waddr (lk_waddr),
      .wdata (lk_wdata),
      .raddr (walk_addr),
      .rdata (link_rd)
   );

   cht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entries (
      .clock (clock),
      .we    (cmd.ent_wr),
      .waddr (slot),
      .wdata ({key_ff, val_ff}),
      .raddr (walk_addr),
      .rdata (ent_rd)
   );

   always_comb begin
      size_in = size_ff;
      fill_in = fill_ff;
      clr_in  = clr_ff;
      cur_in  = cur_ff;
      if (cmd.fill_inc) begin
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.clr_wr) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.walk_head | cmd.walk_next) begin
         cur_in = walk_addr;
      end
      if (csr_we) begin
         size_in = csr_wdata;
         fill_in = FW'(1);
         clr_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in     = 1'b1;
      rsp_in.found     = 1'b0;
      rsp_in.value_out = '0;
      rsp_in.status    = 1'b0;
      unique case (cmd.rsp_code) inside
         cht_pkg::RSP_NONE: rsp_valid_in = 1'b0;
         cht_pkg::RSP_OK, cht_pkg::RSP_MISS: begin
         end
         cht_pkg::RSP_FULL: rsp_in.status = 1'b1;
         cht_pkg::RSP_HIT: begin
            rsp_in.found     = 1'b1;
            rsp_in.value_out = ent_rd[cht_pkg::VAL_W-1:0];
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         fill_ff      <= FW'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
      if (cmd.latch) begin
         key_ff <= req_data.key;
         val_ff <= req_data.value;
      end
   end

   assign stat.full      = (eff_size == '0) || (fill_ff > FW'(eff_size));
   assign stat.size_zero = (eff_size == '0);
   assign stat.mod_done  = mod_done;
   assign stat.head_zero = (head_rd == '0);
   assign stat.link_zero = (link_rd == '0);
   assign stat.key_hit   = (ent_rd[EW-1:cht_pkg::VAL_W] == key_ff);
   assign stat.clr_last  = (clr_ff == IW'(MAX_ENTRIES));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- rtl/cht_ctrl.sv -----
// ---------------------------------------------------------------------------
// cht_ctrl
// Controller: clearing sweep, remainder wait, head fetch and chain walk.
// ---------------------------------------------------------------------------
module cht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_mode,
   input  logic              csr_we,
   input  cht_pkg::stat_type stat,
   output cht_pkg::cmd_type  cmd,
   output logic              busy
);
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_HEAD   = 3'd3;
   localparam logic [2:0] ST_WALK_I = 3'd4;
   localparam logic [2:0] ST_WALK_L = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       mode_ff, mode_in;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               mode_in   = req_mode;
               if (req_mode == cht_pkg::MODE_INSERT && stat.full) begin
                  cmd.rsp_code = cht_pkg::RSP_FULL;
               end else if (req_mode == cht_pkg::MODE_LOOKUP && stat.size_zero) begin
                  cmd.rsp_code = cht_pkg::RSP_MISS;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (stat.mod_done) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (mode_ff == cht_pkg::MODE_INSERT) begin
               cmd.ent_wr = 1'b1;
               if (stat.head_zero) begin
                  cmd.hd_wr    = 1'b1;
                  cmd.fill_inc = 1'b1;
                  cmd.rsp_code = cht_pkg::RSP_OK;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.walk_head = 1'b1;
                  state_in      = ST_WALK_I;
               end
            end else if (stat.head_zero) begin
               cmd.rsp_code = cht_pkg::RSP_MISS;
               state_in     = ST_IDLE;
            end else begin
               cmd.walk_head = 1'b1;
               state_in      = ST_WALK_L;
            end
         end
         ST_WALK_I: begin
            if (stat.link_zero) begin
               cmd.tail_wr  = 1'b1;
               cmd.fill_inc = 1'b1;
               cmd.rsp_code = cht_pkg::RSP_OK;
               state_in     = ST_IDLE;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         ST_WALK_L: begin
            if (stat.key_hit) begin
               cmd.rsp_code = cht_pkg::RSP_HIT;
               state_in     = ST_IDLE;
            end else if (stat.link_zero) begin
               cmd.rsp_code = cht_pkg::RSP_MISS;
               state_in     = ST_IDLE;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (csr_we) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

// ----- rtl/chained_hash_int_table.sv -----
// ---------------------------------------------------------------------------
// chained_hash_int_table
// Key/value table with separate chaining; bucket = 1 + key mod min(table_size, MAX_ENTRIES).
// ---------------------------------------------------------------------------
//  channel | ports                  | handshake
//  --------+------------------------+-------------------------------
//  request | req_data               | taken when start && !busy
//  result  | rsp_data               | one-cycle strobe rsp_valid
//  config  | csr_wdata (table_size) | written when csr_we
//
// A refused insert or a lookup on an empty table is answered straight from idle;
// otherwise the answer waits on the 32-step remainder unit, the head fetch and
// one link RAM read per chain node walked.
// Reset and every table_size write start a clearing sweep of every entry of the
// bucket-head RAM, with busy held high.
// The receiver cannot stall: each result word is shown for one cycle only.
// ---------------------------------------------------------------------------
`include "chained_hash_int_table_defines.svh"

module chained_hash_int_table #(
   parameter int MAX_ENTRIES = cht_pkg::MAX_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cht_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output cht_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [cht_pkg::CFG_W-1:0] csr_wdata
);
   cht_pkg::cmd_type  cmd;
   cht_pkg::stat_type stat;

   // sequence each word: wait on remainder, fetch head, walk the chain
   cht_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .csr_we   (csr_we),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // hold the RAMs, size and fill registers and the result word
   cht_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a hit never carries the refused status
   `CHT_ASSERT(a_hit_not_refused, rsp_valid && rsp_data.found |-> !rsp_data.status, "hit refused")
   // misses and inserts return zero data
   `CHT_ASSERT(a_miss_zero, rsp_valid && !rsp_data.found |-> rsp_data.value_out == 0, "miss data")
   // a reset edge always lands in the clearing sweep
   `CHT_ASSERT_ALWAYS(a_reset_clear, reset |=> busy, "no clear after reset")
endmodule
